// ----- src/bdpc_pkg.sv -----
package bdpc_pkg;

    // APB data and address widths
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // width of each configuration register
    localparam int CFG_W = 16;

    // register indexes (byte address is 4 * index)
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_SHORT    = 2'd1,
        REG_HOLD     = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    // reset values of the registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd15;
    localparam logic [CFG_W-1:0] SHORT_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd3000;

    // events reported with one result beat
    typedef struct packed {
        logic pressed;
        logic released;
        logic short_press;
        logic hold;
    } t_events;

endpackage

// ----- src/button_debounce_press_classifier.sv -----
// Channel   | valid    | stall    | payload
// ----------+----------+----------+---------------------------------------------
// in        | i_valid  | o_stall  | i_pin_level
// out       | o_valid  | i_stall  | o_level_out, o_pressed_event, o_released_event,
//           |          |          | o_short_press_event, o_hold_event
// config    | APB      | pready=1 | psel, penable, pwrite, paddr, pwdata, prdata
//
// One sample per clock while neither stage is stalled; a beat passes from input to output
// through the input register, then the result register.
// The tick state updates once, when a sample leaves the input register.
// i_rst_n is synchronous, active low; it empties both stages and restores the
// register defaults. A stalled output holds its beat; the input register keeps
// taking beats while the result register is free or being drained.
module button_debounce_press_classifier #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_pin_level,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_level_out,
    output logic                           o_pressed_event,
    output logic                           o_released_event,
    output logic                           o_short_press_event,
    output logic                           o_hold_event,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bdpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bdpc_pkg::DATA_W-1:0]    pwdata,
    output logic [bdpc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import bdpc_pkg::*;

    localparam int TW = TICK_COUNTER_BITS;
    // compare width covers both counters and registers
    localparam int CW = (TW > CFG_W) ? TW : CFG_W;
    localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

    // configuration registers
    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_short;
    logic [CFG_W-1:0] r_hold;

    // tick state
    logic          r_filt;
    logic          r_active;
    logic [TW-1:0] r_db_cnt;
    logic          r_stable;
    logic [TW-1:0] r_press_cnt;
    logic          r_armed;

    // input register
    logic r_in_vld;
    logic r_in_pin;

    // result register
    logic    r_out_vld;
    logic    r_out_level;
    t_events r_out_ev;

    logic          n_filt;
    logic          n_active;
    logic [TW-1:0] n_db_cnt;
    logic          n_stable;
    logic [TW-1:0] n_press_cnt;
    logic          n_armed;
    t_events       n_ev;

    logic     w_advance;
    logic     w_cfg_wr;
    t_reg_idx w_idx;
    logic     w_settle;
    logic     w_change;

    assign w_idx    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    // read back the registers
    always_comb begin
        unique case (w_idx)
            REG_DEBOUNCE: prdata = DATA_W'(r_debounce);
            REG_SHORT:    prdata = DATA_W'(r_short);
            REG_HOLD:     prdata = DATA_W'(r_hold);
            default:      prdata = '0;
        endcase
    end

    // write the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_short    <= SHORT_RST;
            r_hold     <= HOLD_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_DEBOUNCE: r_debounce <= pwdata[CFG_W-1:0];
                REG_SHORT:    r_short    <= pwdata[CFG_W-1:0];
                REG_HOLD:     r_hold     <= pwdata[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // move a beat when the result register is free or draining
    assign w_advance = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall   = r_in_vld && !w_advance;

    // debounce, then classify the stable edge
    always_comb begin
        n_filt   = r_filt;
        n_active = r_active;
        n_db_cnt = r_db_cnt;
        n_stable = r_stable;
        n_armed  = r_armed;
        n_ev     = '0;

        // restart the count on any raw change
        if (r_in_pin != r_filt) begin
            n_filt   = r_in_pin;
            n_active = 1'b1;
            n_db_cnt = '0;
        end else if (r_active) begin
            n_db_cnt = (r_db_cnt == TICK_MAX) ? r_db_cnt : r_db_cnt + 1'b1;
        end

        // settle the level once it has held long enough
        w_settle = n_active && (CW'(n_db_cnt) >= CW'(r_debounce));
        if (w_settle) begin
            n_stable = n_filt;
            n_active = 1'b0;
        end
        w_change = w_settle && (n_filt != r_stable);

        n_press_cnt = (r_press_cnt == TICK_MAX) ? r_press_cnt : r_press_cnt + 1'b1;

        // report press or release on a stable edge
        if (w_change) begin
            if (!n_filt) begin
                n_ev.pressed = 1'b1;
                n_press_cnt  = '0;
                n_armed      = 1'b1;
            end else begin
                n_ev.short_press = (CW'(n_press_cnt) <= CW'(r_short));
                n_ev.released    = 1'b1;
                n_armed          = 1'b0;
            end
        end

        // fire the hold once
        if (n_armed && (CW'(n_press_cnt) >= CW'(r_hold))) begin
            n_ev.hold = 1'b1;
            n_armed   = 1'b0;
        end
    end

    // hold the tick state and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt      <= 1'b1;
            r_active    <= 1'b0;
            r_db_cnt    <= '0;
            r_stable    <= 1'b1;
            r_press_cnt <= '0;
            r_armed     <= 1'b0;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_filt      <= n_filt;
                r_active    <= n_active;
                r_db_cnt    <= n_db_cnt;
                r_stable    <= n_stable;
                r_press_cnt <= n_press_cnt;
                r_armed     <= n_armed;
            end
            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_pin <= i_pin_level;
        end
        if (w_advance) begin
            r_out_level <= n_stable;
            r_out_ev    <= n_ev;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_level_out         = r_out_level;
    assign o_pressed_event     = r_out_ev.pressed;
    assign o_released_event    = r_out_ev.released;
    assign o_short_press_event = r_out_ev.short_press;
    assign o_hold_event        = r_out_ev.hold;

    // press and release never share a beat
    a_press_xor_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_pressed_event && o_released_event))
        else $error("press and release in one beat");

    // short press only comes with a release
    a_short_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_short_press_event) |-> o_released_event)
        else $error("short press without release");

    // events agree with the stable level
    a_event_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pressed_event || o_hold_event)) |-> !o_level_out)
        else $error("press or hold while level is released");

    // a moved beat shows up in the result register
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_vld)
        else $error("advanced beat lost");

endmodule

// ----- dv/button_debounce_press_classifier_test.sv -----
`timescale 1ns / 100ps

module button_debounce_press_classifier_test;

    import bdpc_pkg::*;

    localparam logic [15:0] TICK_TOP = 16'hFFFF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_SAMPLES = 400;

    // tracks the debounce and press state and the result beats still owed by the block
    class press_tracker;
        typedef struct {
            logic    level;
            t_events ev;
        } t_tick_result;

        // register copies
        logic [15:0] cfg_deb;
        logic [15:0] cfg_short;
        logic [15:0] cfg_hold;

        // tick state
        logic        filt;
        logic        deb_on;
        logic [15:0] deb_cnt;
        logic        stable;
        logic        prev;
        logic [15:0] press_cnt;
        logic        armed;

        t_tick_result owed[$];
        int errors;
        int n_samples;
        int n_beats;
        int n_press;
        int n_short;
        int n_hold;
        int n_setups;

        function new();
            cfg_deb   = DEBOUNCE_RST;
            cfg_short = SHORT_RST;
            cfg_hold  = HOLD_RST;
            filt      = 1'b1;
            deb_on    = 1'b0;
            deb_cnt   = '0;
            stable    = 1'b1;
            prev      = 1'b1;
            press_cnt = '0;
            armed     = 1'b0;
            errors    = 0;
            n_samples = 0;
            n_beats   = 0;
            n_press   = 0;
            n_short   = 0;
            n_hold    = 0;
            n_setups  = 0;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == TICK_TOP) ? v : v + 16'd1;
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] v);
            case (idx)
                REG_DEBOUNCE: cfg_deb = v;
                REG_SHORT:    cfg_short = v;
                REG_HOLD:     cfg_hold = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // advance one tick and queue the beat it must produce
        function void note_sample(logic pin);
            t_tick_result r;
            n_samples++;
            r.ev = '0;
            // restart the debounce count on any change of the raw level
            if (pin != filt) begin
                filt    = pin;
                deb_on  = 1'b1;
                deb_cnt = '0;
            end else if (deb_on) begin
                deb_cnt = bump(deb_cnt);
            end
            if (deb_on && deb_cnt >= cfg_deb) begin
                stable = filt;
                deb_on = 1'b0;
            end
            press_cnt = bump(press_cnt);
            // classify the stable edge
            if (stable != prev) begin
                if (!stable) begin
                    r.ev.pressed = 1'b1;
                    press_cnt    = '0;
                    armed        = 1'b1;
                    n_press++;
                end else begin
                    if (press_cnt <= cfg_short) begin
                        r.ev.short_press = 1'b1;
                        n_short++;
                    end
                    r.ev.released = 1'b1;
                    armed         = 1'b0;
                end
                prev = stable;
            end
            // fire the hold once per press
            if (armed && press_cnt >= cfg_hold) begin
                r.ev.hold = 1'b1;
                armed     = 1'b0;
                n_hold++;
            end
            r.level = stable;
            owed.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at beat %0d: %s", n_beats, msg);
            errors++;
        endtask

        // compare one accepted result beat with the oldest owed one
        task check_beat(logic level, t_events ev);
            t_tick_result r;
            if (owed.size() == 0) begin
                report("result beat with nothing owed");
            end else begin
                r = owed.pop_front();
                if (level !== r.level)
                    report($sformatf("level_out %b, want %b", level, r.level));
                if (ev.pressed !== r.ev.pressed)
                    report($sformatf("pressed_event %b, want %b", ev.pressed, r.ev.pressed));
                if (ev.released !== r.ev.released)
                    report($sformatf("released_event %b, want %b",
                                     ev.released, r.ev.released));
                if (ev.short_press !== r.ev.short_press)
                    report($sformatf("short_press_event %b, want %b",
                                     ev.short_press, r.ev.short_press));
                if (ev.hold !== r.ev.hold)
                    report($sformatf("hold_event %b, want %b", ev.hold, r.ev.hold));
            end
            n_beats++;
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_pin_level = 1'b1;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_level_out;
    logic              o_pressed_event;
    logic              o_released_event;
    logic              o_short_press_event;
    logic              o_hold_event;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    press_tracker sb = new();
    bit hold_req = 1'b0;
    int burst_left = 0;

    button_debounce_press_classifier dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_pin_level         (i_pin_level),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_level_out         (o_level_out),
        .o_pressed_event     (o_pressed_event),
        .o_released_event    (o_released_event),
        .o_short_press_event (o_short_press_event),
        .o_hold_event        (o_hold_event),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #6 i_clk = ~i_clk;

    // offer one sample; the sender runs in bursts with random gaps between them
    task put_sample(logic pin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_pin_level <= pin;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(pin);
    endtask

    task put_run(logic pin, int len);
        repeat (len) put_sample(pin);
    endtask

    // random chatter of a few samples
    task put_noise(int len);
        repeat (len) put_sample(1'($urandom_range(0, 1)));
    endtask

    // hold off new samples until every owed beat has come back
    task drain;
        i_valid    <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task write_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task setup(logic [15:0] deb, logic [15:0] lim, logic [15:0] hold);
        drain();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_SHORT, lim);
        write_reg(REG_HOLD, hold);
        sb.n_setups++;
    endtask

    // bouncy press and release with durations around the current limits
    task press_cycle;
        int deb;
        int span;
        int low_len;
        int high_len;
        deb  = (sb.cfg_deb > 40) ? 40 : int'(sb.cfg_deb);
        span = (sb.cfg_hold > sb.cfg_short) ? int'(sb.cfg_hold) : int'(sb.cfg_short);
        if (span > 40)
            span = 40;
        low_len  = deb + 1 + $urandom_range(0, span + 4);
        high_len = deb + 1 + $urandom_range(0, 5);
        put_noise($urandom_range(0, 3));
        put_run(1'b0, low_len);
        put_noise($urandom_range(0, 3));
        put_run(1'b1, high_len);
    endtask

    // receiver: stall on a randomly chosen mode, plus one long hold-off
    initial begin
        int mode;
        int cyc;
        int hold_cnt;
        mode     = 0;
        cyc      = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                sb.check_beat(o_level_out, '{o_pressed_event, o_released_event,
                                             o_short_press_event, o_hold_event});
            cyc++;
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_OFF_CYCLES;
                i_stall  <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= cyc[1];
                endcase
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int ph;
        int start;
        int phase_end;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: a glitch back to released before the debounce time
        put_run(1'b1, 2);
        put_run(1'b0, 3);
        put_run(1'b1, 2);

        // zero debounce and zero hold: press, hold and release in single ticks
        drain();
        write_reg(REG_NONE, 16'hFFFF);
        setup(16'd0, 16'd3, 16'd0);
        put_run(1'b0, 3);
        put_sample(1'b1);
        put_run(1'b0, 6);
        put_sample(1'b1);
        put_sample(1'b0);
        put_sample(1'b1);

        // random phases with well-formed presses and some chatter
        start = sb.n_samples;
        for (ph = 0; sb.n_samples - start < RANDOM_SAMPLES; ph++) begin
            case (ph)
                3: setup(16'hFFFF, 16'd0, 16'hFFFF);
                4: setup(16'd0, 16'hFFFF, 16'd0);
                default: setup(($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 4)),
                               16'($urandom_range(0, 12)),
                               ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(0, 24)));
            endcase
            if (ph == 1)
                hold_req = 1'b1;
            phase_end = sb.n_samples + 80;
            while (sb.n_samples < phase_end) begin
                if ($urandom_range(0, 4) == 0)
                    put_noise($urandom_range(1, 8));
                else
                    press_cycle();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d beats never came", sb.pending()));
        $display("%0d samples over %0d register settings, %0d result beats checked",
                 sb.n_samples, sb.n_setups, sb.n_beats);
        $display("%0d presses, %0d short presses, %0d hold events seen",
                 sb.n_press, sb.n_short, sb.n_hold);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
